### sv/swrt_pkg.sv
// Package: shared types, codes and constants of the retransmit tracker.
package swrt_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MAX_SEGMENT = 1024;
  localparam int unsigned WINDOW_RESET = 65535;
  localparam int unsigned RTO_RESET   = 1000;

  localparam logic [2:0] CMD_OPEN = 3'd0;
  localparam logic [2:0] CMD_SEND = 3'd1;
  localparam logic [2:0] CMD_ACK  = 3'd2;
  localparam logic [2:0] CMD_TICK = 3'd3;
  localparam logic [2:0] CMD_FIN  = 3'd4;

  localparam logic [2:0] KIND_ACCEPT = 3'd0;
  localparam logic [2:0] KIND_REFUSE = 3'd1;
  localparam logic [2:0] KIND_RETX   = 3'd2;
  localparam logic [2:0] KIND_ACK    = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  localparam logic [0:0] REG_RTO  = 1'b0;
  localparam logic [0:0] REG_RULE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic              load;     // capture input item
    logic              do_open;
    logic              do_send;  // decide and commit send
    logic              do_fin;
    logic              scan_ack; // process slot scan_idx for ack
    logic              scan_tick;
    logic [SLOT_W-1:0] scan_idx;
  } swrt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic expired; // slot scan_idx busy and timed out
  } swrt_stat_t;

endpackage

### sv/swrt_datapath.sv
// Datapath: slot table, sequence and in-flight state, result formation.
module swrt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swrt_pkg::swrt_cmd_t  cmd_i,
  output swrt_pkg::swrt_stat_t stat_o,
  input  logic [15:0]          rto_ticks_i,
  input  logic                 send_rule_i,
  input  logic [31:0]          initial_seq_i,
  input  logic [10:0]          seg_len_i,
  input  logic [31:0]          ack_num_i,
  input  logic [15:0]          peer_window_i,
  input  logic [31:0]          now_time_i,
  output logic [2:0]           res_kind_o,
  output logic [2:0]           res_slot_o,
  output logic [31:0]          res_seq_o,
  output logic [10:0]          res_len_o,
  output logic [16:0]          res_inflight_o
);
  import swrt_pkg::*;

  logic [31:0] iseq_q, ack_q, now_q;
  logic [10:0] len_q;
  logic [15:0] pwin_q;
  logic [31:0] next_seq_q;
  logic [16:0] inflight_q;
  logic [15:0] window_q;
  logic [SLOTS-1:0] busy_q;
  logic [31:0] sseq_q [SLOTS];
  logic [10:0] slen_q [SLOTS];
  logic [31:0] stime_q [SLOTS];

  logic [SLOT_W-1:0] free_idx;
  logic              free_any;
  logic              ok;
  logic [17:0]       sum;
  logic [31:0]       end_seq, ack_diff, age;
  logic [SLOT_W-1:0] si;

  assign si = cmd_i.scan_idx;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
    sum = 18'(inflight_q) + 18'(len_q);
    if (!send_rule_i) ok = sum <= 18'(window_q);
    else ok = inflight_q < 17'(window_q);
    ok = ok && (len_q != 11'd0) && (32'(len_q) <= 32'(MAX_SEGMENT)) && free_any;
    end_seq  = sseq_q[si] + 32'(slen_q[si]);
    ack_diff = ack_q - end_seq;
    age      = now_q - stime_q[si];
  end

  assign stat_o.expired = busy_q[si] && (age >= 32'(rto_ticks_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q <= '0;
      inflight_q <= '0;
      window_q   <= 16'(WINDOW_RESET);
      busy_q     <= '0;
    end else begin
      if (cmd_i.do_open) begin
        busy_q     <= '0;
        next_seq_q <= iseq_q + 32'd1;
        inflight_q <= '0;
        window_q   <= pwin_q;
      end
      if (cmd_i.do_send && ok) begin
        busy_q[free_idx] <= 1'b1;
        inflight_q <= sum[16:0];
        next_seq_q <= next_seq_q + 32'(len_q);
      end
      if (cmd_i.do_fin) next_seq_q <= next_seq_q + 32'd1;
      if (cmd_i.scan_ack) begin
        if (busy_q[si] && !ack_diff[31]) begin
          busy_q[si] <= 1'b0;
          inflight_q <= (inflight_q >= 17'(slen_q[si])) ?
                        inflight_q - 17'(slen_q[si]) : '0;
        end
        window_q <= pwin_q;
      end
    end
  end

  // Payload registers: inputs and slot contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      iseq_q <= initial_seq_i;
      len_q  <= seg_len_i;
      ack_q  <= ack_num_i;
      pwin_q <= peer_window_i;
      now_q  <= now_time_i;
    end
    if (cmd_i.do_send && ok) begin
      sseq_q[free_idx]  <= next_seq_q;
      slen_q[free_idx]  <= len_q;
      stime_q[free_idx] <= now_q;
    end
    if (cmd_i.scan_tick && stat_o.expired) stime_q[si] <= now_q;
  end

  // Result fields are formed combinationally and captured by the controller.
  always_comb begin
    res_kind_o     = KIND_DONE;
    res_slot_o     = '0;
    res_seq_o      = '0;
    res_len_o      = '0;
    res_inflight_o = inflight_q;
    if (cmd_i.do_open) begin
      res_seq_o = iseq_q;
      res_inflight_o = '0;
    end else if (cmd_i.do_fin) begin
      res_seq_o = next_seq_q;
    end else if (cmd_i.do_send) begin
      res_kind_o = ok ? KIND_ACCEPT : KIND_REFUSE;
      res_slot_o = ok ? 3'(free_idx) : 3'd0;
      res_seq_o  = next_seq_q;
      res_len_o  = len_q;
      res_inflight_o = ok ? sum[16:0] : inflight_q;
    end else if (cmd_i.scan_tick) begin
      res_kind_o = KIND_RETX;
      res_slot_o = 3'(si);
      res_seq_o  = sseq_q[si];
      res_len_o  = slen_q[si];
    end else if (cmd_i.scan_ack) begin
      res_kind_o = KIND_ACK;
    end
  end

endmodule

### sv/swrt_ctrl.sv
// Controller: sequences commands and slot scans, owns the output register.
module swrt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  output swrt_pkg::swrt_cmd_t  dp_o,
  input  swrt_pkg::swrt_stat_t stat_i,
  input  logic [2:0]           res_kind_i,
  input  logic [2:0]           res_slot_i,
  input  logic [31:0]          res_seq_i,
  input  logic [10:0]          res_len_i,
  input  logic [16:0]          res_inflight_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           kind_o,
  output logic [2:0]           slot_o,
  output logic [31:0]          seq_out_o,
  output logic [10:0]          len_out_o,
  output logic [16:0]          inflight_out_o,
  output logic                 last_o
);
  import swrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OPEN, S_SEND, S_FIN, S_ACK, S_ACK_END, S_TICK, S_WAIT
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              pend_q, pend_d;   // a retransmit held, not yet emitted
  logic              ov_q, ov_d;
  logic              emit;
  logic              done_scan;
  logic [2:0]        kind_q;
  logic [2:0]        slot_q;
  logic [31:0]       seq_q;
  logic [10:0]       len_q;
  logic [16:0]       infl_q;
  logic              last_q, last_d;
  logic              capture;
  logic              out_free;
  logic [SLOT_W-1:0] held_idx_q;
  logic [31:0]       held_seq_q;
  logic [10:0]       held_len_q;

  assign out_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign done_scan = (32'(idx_q) == 32'(SLOTS - 1));

  // The tick scan holds an expired slot until the next expired slot or the end
  // of the scan is found, so its last flag can see whether any later slot expired.
  always_comb begin
    dp_o = '0;
    dp_o.scan_idx = idx_q;
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    capture = 1'b0;
    last_d  = 1'b1;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          dp_o.load = 1'b1;
          idx_d = '0;
          pend_d = 1'b0;
          unique case (cmd_i)
            CMD_OPEN: state_d = S_OPEN;
            CMD_SEND: state_d = S_SEND;
            CMD_ACK:  state_d = S_ACK;
            CMD_TICK: state_d = S_TICK;
            CMD_FIN:  state_d = S_FIN;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_OPEN, S_SEND, S_FIN: begin
        if (out_free) begin
          dp_o.do_open = (state_q == S_OPEN);
          dp_o.do_send = (state_q == S_SEND);
          dp_o.do_fin  = (state_q == S_FIN);
          capture = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ACK: begin
        // Walk every slot; the result forms once the last slot has landed.
        dp_o.scan_ack = 1'b1;
        if (done_scan) state_d = S_ACK_END;
        else idx_d = idx_q + SLOT_W'(1);
      end
      S_ACK_END: begin
        // The last slot is free or still uncovered here, so revisiting it
        // changes nothing.
        dp_o.scan_ack = out_free;
        capture = out_free;
        if (out_free) state_d = S_IDLE;
      end
      S_TICK: begin
        // A held retransmit is emitted once the next expiry (or end) is known.
        if (stat_i.expired && pend_q) begin
          if (out_free) begin
            emit = 1'b1;
            last_d = 1'b0;
          end
        end
        if (!(stat_i.expired && pend_q) || out_free) begin
          if (stat_i.expired) pend_d = 1'b1;
          if (done_scan) begin
            state_d = S_WAIT;
          end else begin
            idx_d = idx_q + SLOT_W'(1);
          end
        end
        dp_o.scan_tick = (!(stat_i.expired && pend_q) || out_free);
      end
      S_WAIT: begin
        if (!pend_q) state_d = S_IDLE;
        else if (out_free) begin
          emit = 1'b1;
          state_d = S_IDLE;
          pend_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = capture || emit || (ov_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      kind_q <= res_kind_i;
      slot_q <= res_slot_i;
      seq_q  <= res_seq_i;
      len_q  <= res_len_i;
      infl_q <= res_inflight_i;
      last_q <= 1'b1;
    end else if (emit) begin
      kind_q <= KIND_RETX;
      slot_q <= 3'(held_idx_q);
      seq_q  <= held_seq_q;
      len_q  <= held_len_q;
      infl_q <= res_inflight_i;
      last_q <= last_d;
    end
    if (dp_o.scan_tick && stat_i.expired) begin
      held_idx_q <= idx_q;
      held_seq_q <= res_seq_i;
      held_len_q <= res_len_i;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign slot_o         = slot_q;
  assign seq_out_o      = seq_q;
  assign len_out_o      = len_q;
  assign inflight_out_o = infl_q;
  assign last_o         = last_q;

endmodule

### sv/sliding_window_retransmit_tracker_top.sv
// Top level of the sliding-window sender bookkeeping block.
// Each accepted item is one command: open, send, ack, tick or fin. Open, send
// and fin give one result each. Ack walks the slot table, one slot a cycle,
// then forms its one result. Tick walks the table the same way, but stalls
// while a held retransmit waits for the output register, and gives one
// retransmit per expired slot, lowest slot first, with last set on the final
// one; a tick that finds nothing gives no result. The one slot-table scan sets
// the rate; the next item is taken once the current one is done and the output
// register is free. Configuration (index 0 timeout, 1 send rule) is to be
// written while idle; the block itself does not enforce this. The index is one
// bit wide, so there are no other indexes. Codes 5 to 7 are dropped.
module sliding_window_retransmit_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] initial_seq_i,
  input  logic [10:0] seg_len_i,
  input  logic [31:0] ack_num_i,
  input  logic [15:0] peer_window_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic [31:0] seq_out_o,
  output logic [10:0] len_out_o,
  output logic [16:0] inflight_out_o,
  output logic        last_o
);
  import swrt_pkg::*;

  logic [15:0] rto_q;
  logic        rule_q;
  swrt_cmd_t   dp_cmd;
  swrt_stat_t  dp_stat;
  logic [2:0]  r_kind, r_slot;
  logic [31:0] r_seq;
  logic [10:0] r_len;
  logic [16:0] r_infl;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers; only the listed indexes land.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rto_q  <= 16'(RTO_RESET);
      rule_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RTO:  rto_q  <= cfg_data_i;
        REG_RULE: rule_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  swrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i,
    .dp_o(dp_cmd), .stat_i(dp_stat),
    .res_kind_i(r_kind), .res_slot_i(r_slot), .res_seq_i(r_seq),
    .res_len_i(r_len), .res_inflight_i(r_infl),
    .out_valid_o, .out_ready_i, .kind_o, .slot_o, .seq_out_o,
    .len_out_o, .inflight_out_o, .last_o
  );

  swrt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .stat_o(dp_stat),
    .rto_ticks_i(rto_q), .send_rule_i(rule_q),
    .initial_seq_i, .seg_len_i, .ack_num_i, .peer_window_i, .now_time_i,
    .res_kind_o(r_kind), .res_slot_o(r_slot), .res_seq_o(r_seq),
    .res_len_o(r_len), .res_inflight_o(r_infl)
  );

  // A new item is never taken while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("item accepted over a stalled result");

  // A retransmit never reports an empty segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_RETX |-> len_out_o != 11'd0)
    else $error("retransmit with zero length");

  // Non-retransmit results are always the final result of their item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_RETX |-> last_o)
    else $error("single result without last");

endmodule
